// ===== sv/bfcrc_pkg.sv =====
package bfcrc_pkg;

   // crc_a preset and i-block control bytes
   localparam logic [15:0] CRC_PRESET  = 16'h6363;
   localparam logic [7:0]  IBLOCK_EVEN = 8'h02;
   localparam logic [7:0]  IBLOCK_ODD  = 8'h03;

   // positions in the request tuser field
   localparam int USER_FIRST = 0;
   localparam int USER_SETPCB = 1;

   // which result of an item is on the output
   typedef enum logic [1:0] {
      SLOT_DATA   = 2'd0,
      SLOT_CRC_LO = 2'd1,
      SLOT_CRC_HI = 2'd2
   } slot_type;

   // one byte folded into the reflected crc_a
   function automatic logic [15:0] crc_a_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  t;
      logic [15:0] t16;
      t   = b ^ crc[7:0];
      t   = t ^ {t[3:0], 4'b0000};
      t16 = {8'h00, t};
      return {8'h00, crc[15:8]} ^ (t16 << 8) ^ (t16 << 3) ^ (t16 >> 4);
   endfunction

endpackage

// ===== sv/block_frame_crc_a_appender_core.sv =====
// frame byte stream in, framed stream with crc_a trailer out
// req channel: one frame byte per transfer, tlast marks the final payload byte,
//    tuser[0] marks the first byte (crc restarts), tuser[1] on a first byte swaps
//    it for the i-block control byte 0x02/0x03 from a toggling block-number bit
// rsp channel: the emitted byte, then on a last byte the crc low and high bytes,
//    tlast set on the crc high byte that ends the frame
// a request byte is registered and appears on rsp in the cycle after its transfer
// throughput: one byte per cycle for payload bytes while rsp_tready stays high; a last
//    byte occupies the output register for its byte, crc low and crc high in turn;
//    the limit is the single output register
// a new request is taken in the same cycle as the final result of the previous
//    one leaves, so a stalled receiver holds back the request side directly
// reset: crc preset to 0x6363, block-number bit cleared, output empty
module block_frame_crc_a_appender_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // last_byte
   input  logic [1:0] req_tuser,   // first_byte, set_block_number
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // frame_end
);

   logic                 valid_ff, valid_in;
   bfcrc_pkg::slot_type  slot_ff, slot_in;
   logic                 has_crc_ff, has_crc_in;
   logic [7:0]           byte_ff, byte_in;
   logic [15:0]          crc_out_ff, crc_out_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 toggle_ff, toggle_in;

   logic        req_xfer;
   logic        rsp_xfer;
   logic        final_shown;
   logic        first;
   logic        setpcb;
   logic [7:0]  emit_byte;
   logic [15:0] crc_base;
   logic [15:0] crc_fold;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // last result of the held item is on the output
   assign final_shown = (slot_ff == bfcrc_pkg::SLOT_CRC_HI) ||
                        ((slot_ff == bfcrc_pkg::SLOT_DATA) && !has_crc_ff);
   assign req_tready  = !valid_ff || (rsp_tready && final_shown);

   // control byte substitution and crc update
   always_comb begin
      first     = req_tuser[bfcrc_pkg::USER_FIRST];
      setpcb    = req_tuser[bfcrc_pkg::USER_SETPCB];
      emit_byte = req_tdata;
      toggle_in = toggle_ff;
      if (first && setpcb) begin
         emit_byte = toggle_ff ? bfcrc_pkg::IBLOCK_ODD : bfcrc_pkg::IBLOCK_EVEN;
      end
      if (req_xfer && first && setpcb) begin
         toggle_in = !toggle_ff;
      end
      crc_base = first ? bfcrc_pkg::CRC_PRESET : crc_ff;
      crc_fold = bfcrc_pkg::crc_a_fold(crc_base, emit_byte);
      crc_in   = crc_ff;
      if (req_xfer) begin
         crc_in = req_tlast ? bfcrc_pkg::CRC_PRESET : crc_fold;
      end
   end

   // output register sequencing
   always_comb begin
      valid_in   = valid_ff;
      slot_in    = slot_ff;
      has_crc_in = has_crc_ff;
      byte_in    = byte_ff;
      crc_out_in = crc_out_ff;
      if (rsp_xfer) begin
         case (slot_ff)
            bfcrc_pkg::SLOT_DATA: begin
               if (has_crc_ff) begin
                  slot_in = bfcrc_pkg::SLOT_CRC_LO;
               end else begin
                  valid_in = 1'b0;
               end
            end
            bfcrc_pkg::SLOT_CRC_LO: begin
               slot_in = bfcrc_pkg::SLOT_CRC_HI;
            end
            default: begin
               valid_in = 1'b0;
            end
         endcase
      end
      if (req_xfer) begin
         valid_in   = 1'b1;
         slot_in    = bfcrc_pkg::SLOT_DATA;
         has_crc_in = req_tlast;
         byte_in    = emit_byte;
         crc_out_in = crc_fold;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         slot_ff    <= bfcrc_pkg::SLOT_DATA;
         has_crc_ff <= 1'b0;
         crc_ff     <= bfcrc_pkg::CRC_PRESET;
         toggle_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         slot_ff    <= slot_in;
         has_crc_ff <= has_crc_in;
         crc_ff     <= crc_in;
         toggle_ff  <= toggle_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      crc_out_ff <= crc_out_in;
   end

   // result selection
   always_comb begin
      case (slot_ff)
         bfcrc_pkg::SLOT_DATA:   rsp_tdata = byte_ff;
         bfcrc_pkg::SLOT_CRC_LO: rsp_tdata = crc_out_ff[7:0];
         default:                rsp_tdata = crc_out_ff[15:8];
      endcase
   end
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = (slot_ff == bfcrc_pkg::SLOT_CRC_HI);

   // frame end is flagged only on the crc high byte
   a_end_on_hi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> has_crc_ff)
      else $error("frame end without a crc trailer");

   // a last byte brings its trailer with it
   a_last_loads_trailer: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> rsp_tvalid && has_crc_ff &&
                                (slot_ff == bfcrc_pkg::SLOT_DATA))
      else $error("trailer not scheduled after last byte");

   // no request is taken while pending results cannot leave
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_xfer && rsp_tvalid |-> rsp_tready && final_shown)
      else $error("request taken over pending results");

   // crc low is always followed by crc high
   a_lo_then_hi: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (slot_ff == bfcrc_pkg::SLOT_CRC_LO) |=>
         rsp_tvalid && (slot_ff == bfcrc_pkg::SLOT_CRC_HI))
      else $error("crc high byte missing");

   // crc register is back at preset after a frame ends
   a_crc_preset: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> crc_ff == bfcrc_pkg::CRC_PRESET)
      else $error("crc not preset after frame");

endmodule
